>>> rtl/ecsl_pkg.sv
// ----------------------------------------------------------------------------
// ecsl_pkg: shared types and constants for the slice locator
// Status codes, widths and the controller/datapath command and status structs.
// ----------------------------------------------------------------------------
package ecsl_pkg;

    localparam int MAX_CHUNKS_DEF = 16;
    localparam int MAX_PIECES_DEF = 64;

    localparam int IN_TDATA_W  = 136;  // 133 bits of fields, padded to bytes
    localparam int OUT_TDATA_W = 112;  // 109 bits of fields, padded to bytes

    localparam int CFG_IDX_W  = 1;
    localparam int CFG_DATA_W = 7;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_DATA_FRAGMENTS = 1'b0,
        CFG_CHUNKS_IN_USE  = 1'b1
    } t_cfg_idx;

    typedef enum logic [1:0] {
        ST_OK       = 2'd0,
        ST_PAST_END = 2'd1,
        ST_ZERO_FRG = 2'd2,
        ST_CAP      = 2'd3
    } t_status;

    // Controller to datapath commands.
    typedef struct packed {
        logic start;      // capture item and chunk count, clear slice position and piece count
        logic walk_init;  // restart chunk walk from entry 0
        logic walk_step;  // consume table read data, advance
        logic div1_start; // csize / k
        logic div2_start; // pin_chunk / flen
        logic emit;       // load output register with piece or error
        logic advance;    // move offset by piece length
    } t_cmd;

    // Datapath to controller status.
    typedef struct packed {
        logic remaining_zero;
        logic walk_found;
        logic walk_end;
        logic div_busy;
        logic flen_zero;
        logic last_emitted;  // emitted result closes the item
        logic out_busy;      // output register still holds a result
    } t_sts;

endpackage

>>> rtl/ecsl_ram.sv
// ----------------------------------------------------------------------------
// ecsl_ram: generic single-port-write, registered-read RAM
// One write and one read address per cycle.
// ----------------------------------------------------------------------------
module ecsl_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 16
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;
endmodule

>>> rtl/ecsl_div.sv
// ----------------------------------------------------------------------------
// ecsl_div: radix-2 restoring divider, 32-bit dividend
// One quotient bit per cycle; quotient and remainder held until next start.
// ----------------------------------------------------------------------------
module ecsl_div (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_start,
    input  logic [31:0] i_dividend,
    input  logic [31:0] i_divisor,
    output logic        o_busy,
    output logic [31:0] o_quot,
    output logic [31:0] o_rem
);
    logic [31:0] r_quot, r_rem, r_dvs;
    logic [5:0]  r_cnt;
    logic        r_busy;
    logic [32:0] w_trial;

    assign w_trial = {r_rem, r_quot[31]} - {1'b0, r_dvs};

    // Shift-subtract iteration.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_cnt  <= '0;
        end else if (i_start) begin
            r_busy <= 1'b1;
            r_cnt  <= 6'd32;
            r_quot <= i_dividend;
            r_rem  <= '0;
            r_dvs  <= i_divisor;
        end else if (r_busy) begin
            if (!w_trial[32]) begin
                r_rem <= w_trial[31:0];
                r_quot <= {r_quot[30:0], 1'b1};
            end else begin
                r_rem <= {r_rem[30:0], r_quot[31]};
                r_quot <= {r_quot[30:0], 1'b0};
            end
            r_cnt <= r_cnt - 6'd1;
            if (r_cnt == 6'd1) begin
                r_busy <= 1'b0;
            end
        end
    end

    assign o_busy = r_busy;
    assign o_quot = r_quot;
    assign o_rem  = r_rem;
endmodule

>>> rtl/ecsl_datapath.sv
// ----------------------------------------------------------------------------
// ecsl_datapath: chunk table, walk registers, shared divider, output register
// Executes controller commands one step at a time.
// ----------------------------------------------------------------------------
module ecsl_datapath #(
    parameter int MAX_CHUNKS = 16,
    parameter int MAX_PIECES = 64
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  ecsl_pkg::t_cmd              i_cmd,
    output ecsl_pkg::t_sts              o_sts,
    input  logic                        i_load_we,
    input  logic [3:0]                  i_load_slot,
    input  logic [31:0]                 i_load_bytes,
    input  logic [63:0]                 i_offset,
    input  logic [31:0]                 i_length,
    input  logic [6:0]                  i_k,
    input  logic [4:0]                  i_chunks,
    output logic                        o_valid,
    input  logic                        i_ready,
    output logic [ecsl_pkg::OUT_TDATA_W-1:0] o_data,
    output logic                        o_last
);
    import ecsl_pkg::*;

    localparam int AW = (MAX_CHUNKS > 1) ? $clog2(MAX_CHUNKS) : 1;
    localparam int CW = $clog2(MAX_CHUNKS + 1);
    localparam int PW = $clog2(MAX_PIECES + 1);

    // Which division the shared divider is running.
    typedef enum logic [1:0] {
        DIV_IDLE,
        DIV_FLEN,
        DIV_FRAG
    } t_div_sel;

    logic [63:0] r_pos, r_base;
    logic [31:0] r_rem_len, r_spos, r_csize, r_flen, r_plen;
    logic [CW-1:0] r_ci, r_used;
    logic [3:0]  r_hit_ci;
    logic [PW-1:0] r_count;
    logic        r_found;
    t_div_sel    r_div_sel;
    logic        r_ovalid;
    logic [OUT_TDATA_W-1:0] r_odata;
    logic        r_olast;

    logic [31:0] w_rdata, w_quot, w_qrem, w_avail, w_plen, w_div_a, w_div_b;
    logic        w_div_busy, w_div_start;
    logic [AW-1:0] w_raddr, w_waddr;
    logic        w_we;
    logic [64:0] w_end;
    t_status     w_status;
    logic        w_cap;

    // Table write: slot beyond the table is dropped.
    assign w_we    = i_load_we && ({28'd0, i_load_slot} < 32'(MAX_CHUNKS));
    assign w_waddr = AW'(i_load_slot);
    assign w_raddr = r_ci[AW-1:0];

    ecsl_ram #(.WIDTH(32), .DEPTH(MAX_CHUNKS)) u_table (
        .i_clk(i_clk), .i_we(w_we), .i_waddr(w_waddr), .i_wdata(i_load_bytes),
        .i_raddr(w_raddr), .o_rdata(w_rdata)
    );

    // Divider shared by both divisions.
    assign w_div_start = i_cmd.div1_start | i_cmd.div2_start;
    assign w_div_a = i_cmd.div1_start ? r_csize : 32'(r_pos - r_base);
    assign w_div_b = i_cmd.div1_start ? {25'd0, i_k} : r_flen;

    ecsl_div u_div (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_start(w_div_start),
        .i_dividend(w_div_a), .i_divisor(w_div_b),
        .o_busy(w_div_busy), .o_quot(w_quot), .o_rem(w_qrem)
    );

    assign w_end   = {1'b0, r_base} + {33'd0, w_rdata};
    assign w_avail = r_flen - w_qrem;
    assign w_plen  = (r_rem_len < w_avail) ? r_rem_len : w_avail;
    assign w_cap   = (r_count == PW'(MAX_PIECES - 1)) && (w_plen < r_rem_len);

    always_comb begin
        priority if (!r_found)   w_status = ST_PAST_END;
        else if (r_flen == '0)   w_status = ST_ZERO_FRG;
        else if (w_cap)          w_status = ST_CAP;
        else                     w_status = ST_OK;
    end

    // Walk, division and piece registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ovalid  <= 1'b0;
            r_count   <= '0;
            r_found   <= 1'b0;
            r_div_sel <= DIV_IDLE;
        end else begin
            if (o_valid && i_ready) begin
                r_ovalid <= 1'b0;
            end
            if (i_cmd.start) begin
                r_pos     <= i_offset;
                r_rem_len <= i_length;
                r_spos    <= '0;
                r_count   <= '0;
                r_used    <= ({27'd0, i_chunks} > 32'(MAX_CHUNKS)) ?
                             CW'(MAX_CHUNKS) : CW'(i_chunks);
            end
            if (i_cmd.walk_init) begin
                r_ci    <= '0;
                r_base  <= '0;
                r_found <= 1'b0;
            end
            if (i_cmd.walk_step) begin
                if (w_end > {1'b0, r_pos}) begin
                    r_found  <= 1'b1;
                    r_csize  <= w_rdata;
                    r_hit_ci <= 4'(r_ci);
                end else begin
                    r_base <= w_end[63:0];
                    r_ci   <= r_ci + CW'(1);
                end
            end
            if (w_div_start) begin
                r_div_sel <= i_cmd.div1_start ? DIV_FLEN : DIV_FRAG;
            end
            // Once the divider has dropped busy, a csize / k result is registered into r_flen.
            if (r_div_sel != DIV_IDLE && !w_div_busy && !w_div_start) begin
                if (r_div_sel == DIV_FLEN) begin
                    r_flen <= (i_k == '0) ? '0 : w_quot;
                end
                r_div_sel <= DIV_IDLE;
            end
            if (i_cmd.emit) begin
                r_ovalid <= 1'b1;
                r_plen   <= w_plen;
                r_olast  <= (w_status != ST_OK) || (w_plen == r_rem_len);
                if (w_status == ST_OK) begin
                    r_odata <= {3'd0, w_status, r_spos, w_plen, w_qrem,
                                w_quot[6:0], r_hit_ci};
                end else begin
                    r_odata <= {3'd0, w_status, r_spos, 32'd0, 32'd0, 7'd0, 4'd0};
                end
                r_count  <= r_count + PW'(1);
            end
            if (i_cmd.advance) begin
                r_rem_len <= r_rem_len - r_plen;
                r_pos     <= r_pos + {32'd0, r_plen};
                r_spos    <= r_spos + r_plen;
            end
        end
    end

    // Chunk size zero ends never match; walk end is a count compare.
    assign o_sts.remaining_zero = (r_rem_len == '0);
    assign o_sts.walk_found     = (w_end > {1'b0, r_pos});
    assign o_sts.walk_end       = (r_ci >= r_used);
    assign o_sts.div_busy       = w_div_busy || (r_div_sel != DIV_IDLE);
    assign o_sts.flen_zero      = (r_flen == '0);
    assign o_sts.last_emitted   = r_olast;
    assign o_sts.out_busy       = r_ovalid;

    assign o_valid = r_ovalid;
    assign o_data  = r_odata;
    assign o_last  = r_olast;
endmodule

>>> rtl/ecsl_ctrl.sv
// ----------------------------------------------------------------------------
// ecsl_ctrl: sequencer for load and resolve items
// Steps walk, divisions, emit and advance for each piece.
// ----------------------------------------------------------------------------
module ecsl_ctrl (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_in_valid,
    input  logic           i_func,
    output logic           o_in_ready,
    output logic           o_load_we,
    output ecsl_pkg::t_cmd o_cmd,
    input  ecsl_pkg::t_sts i_sts
);
    import ecsl_pkg::*;

    typedef enum logic [3:0] {
        S_IDLE, S_CHECK, S_WALK_RD, S_WALK, S_DIV1, S_DIV1_W, S_DIV2, S_DIV2_W,
        S_EMIT, S_WAIT_OUT, S_ERR
    } t_state;

    t_state r_state, n_state;
    t_cmd   w_cmd;
    logic   w_acc;

    assign o_in_ready = (r_state == S_IDLE) && !i_sts.out_busy;
    assign w_acc      = i_in_valid && o_in_ready;
    assign o_load_we  = w_acc && !i_func;

    always_comb begin
        n_state = r_state;
        w_cmd   = '0;
        unique case (r_state)
            S_IDLE: begin
                if (w_acc && i_func) begin
                    w_cmd.start = 1'b1;
                    n_state = S_CHECK;
                end
            end
            S_CHECK: begin
                if (i_sts.remaining_zero) begin
                    n_state = S_IDLE;
                end else begin
                    w_cmd.walk_init = 1'b1;
                    n_state = S_WALK_RD;
                end
            end
            S_WALK_RD: begin
                // Entry r_ci is read this cycle; stop once the used entries run out.
                if (i_sts.walk_end) begin
                    n_state = S_ERR;
                end else begin
                    n_state = S_WALK;
                end
            end
            S_WALK: begin
                // Read data of entry r_ci arrives now.
                w_cmd.walk_step = 1'b1;
                if (i_sts.walk_found) begin
                    n_state = S_DIV1;
                end else begin
                    n_state = S_WALK_RD;
                end
            end
            S_DIV1: begin
                w_cmd.div1_start = 1'b1;
                n_state = S_DIV1_W;
            end
            S_DIV1_W: begin
                if (!i_sts.div_busy) begin
                    n_state = i_sts.flen_zero ? S_ERR : S_DIV2;
                end
            end
            S_DIV2: begin
                w_cmd.div2_start = 1'b1;
                n_state = S_DIV2_W;
            end
            S_DIV2_W: begin
                if (!i_sts.div_busy && !i_sts.out_busy) begin
                    w_cmd.emit = 1'b1;
                    n_state = S_EMIT;
                end
            end
            S_EMIT: begin
                if (i_sts.last_emitted) begin
                    n_state = S_IDLE;
                end else begin
                    w_cmd.advance = 1'b1;
                    n_state = S_CHECK;
                end
            end
            S_ERR: begin
                if (!i_sts.out_busy) begin
                    w_cmd.emit = 1'b1;
                    n_state = S_WAIT_OUT;
                end
            end
            S_WAIT_OUT: n_state = S_IDLE;
            default:    n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    assign o_cmd = w_cmd;
endmodule

>>> rtl/erasure_coded_slice_locator.sv
// ----------------------------------------------------------------------------
// erasure_coded_slice_locator: resolves an object byte range into fragment pieces
//
//  Channel    | Dir | Payload
//  s_axis     | in  | tdata: func, chunk_slot, chunk_bytes, object_offset, slice_length
//  m_axis     | out | tdata: chunk idx .. slice_position, status; tlast: last_piece
//  cfg write  | in  | i_cfg_we / i_cfg_idx / i_cfg_data
//
// One item at a time, accepted only while idle; an empty slice emits nothing. For
// each piece a resolve walks the chunk table from entry 0, then waits on two
// divisions on the shared radix-2 divider. The input stalls until the previous
// result is taken. Reset is synchronous; the chunk table is not cleared.
// ----------------------------------------------------------------------------
module erasure_coded_slice_locator #(
    parameter int MAX_CHUNKS = ecsl_pkg::MAX_CHUNKS_DEF,
    parameter int MAX_PIECES = ecsl_pkg::MAX_PIECES_DEF
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_cfg_we,
    input  logic [ecsl_pkg::CFG_IDX_W-1:0]    i_cfg_idx,
    input  logic [ecsl_pkg::CFG_DATA_W-1:0]   i_cfg_data,
    input  logic                              s_axis_tvalid,
    output logic                              s_axis_tready,
    // func[0], chunk_slot[4:1], chunk_bytes[36:5], object_offset[100:37],
    // slice_length[132:101]
    input  logic [ecsl_pkg::IN_TDATA_W-1:0]   s_axis_tdata,
    output logic                              m_axis_tvalid,
    input  logic                              m_axis_tready,
    // chunk idx[3:0], frag idx[10:4], fragment_offset[42:11],
    // piece_length[74:43], slice_position[106:75], status[108:107]
    output logic [ecsl_pkg::OUT_TDATA_W-1:0]  m_axis_tdata,
    output logic                              m_axis_tlast
);
    import ecsl_pkg::*;

    logic [6:0] r_k;
    logic [4:0] r_chunks;
    t_cmd       w_cmd;
    t_sts       w_sts;
    logic       w_load_we;

    // Configuration registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_k      <= 7'd1;
            r_chunks <= 5'd1;
        end else if (i_cfg_we) begin
            unique case (t_cfg_idx'(i_cfg_idx))
                CFG_DATA_FRAGMENTS: r_k      <= i_cfg_data;
                CFG_CHUNKS_IN_USE:  r_chunks <= i_cfg_data[4:0];
                default: ;
            endcase
        end
    end

    ecsl_ctrl u_ctrl (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_in_valid(s_axis_tvalid),
        .i_func(s_axis_tdata[0]), .o_in_ready(s_axis_tready),
        .o_load_we(w_load_we), .o_cmd(w_cmd), .i_sts(w_sts)
    );

    ecsl_datapath #(.MAX_CHUNKS(MAX_CHUNKS), .MAX_PIECES(MAX_PIECES)) u_dp (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_cmd(w_cmd), .o_sts(w_sts),
        .i_load_we(w_load_we), .i_load_slot(s_axis_tdata[4:1]),
        .i_load_bytes(s_axis_tdata[36:5]), .i_offset(s_axis_tdata[100:37]),
        .i_length(s_axis_tdata[132:101]), .i_k(r_k), .i_chunks(r_chunks),
        .o_valid(m_axis_tvalid), .i_ready(m_axis_tready),
        .o_data(m_axis_tdata), .o_last(m_axis_tlast)
    );

    // Input is held off while a result waits.
    a_no_accept_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && !m_axis_tready |-> !s_axis_tready)
        else $error("input accepted while result pending");
    // Error results always close the item.
    a_err_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && (t_status'(m_axis_tdata[108:107]) != ST_OK) |-> m_axis_tlast)
        else $error("error result without last");
    // Error results carry no piece length.
    a_err_len: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && (t_status'(m_axis_tdata[108:107]) != ST_OK)
        |-> m_axis_tdata[74:43] == '0)
        else $error("error result with nonzero length");
endmodule
